### src/alc_pkg.sv
// alc_pkg: shared types and constants for the array list block.
// No dependencies; used by alc_cell and array_list_insert_delete.
package alc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // per-cell update select, at most one member set
  typedef struct packed {
    logic load_val;    // take the inserted word
    logic take_left;   // take lower neighbor (shift up)
    logic take_right;  // take upper neighbor (shift down)
  } cell_ctl_t;

endpackage

### src/alc_cell.sv
// alc_cell: one storage cell of the list row, holds one word.
// Depends on alc_pkg (cell_ctl_t, DataW).
module alc_cell (
  input  logic                           clk_i,
  input  alc_pkg::cell_ctl_t             ctl_i,
  input  logic [alc_pkg::DataW-1:0]      value_i,
  input  logic [alc_pkg::DataW-1:0]      left_i,
  input  logic [alc_pkg::DataW-1:0]      right_i,
  output logic [alc_pkg::DataW-1:0]      word_o
);

  logic [alc_pkg::DataW-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.load_val) begin
      word_d = value_i;
    end else if (ctl_i.take_left) begin
      word_d = left_i;
    end else if (ctl_i.take_right) begin
      word_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

### src/array_list_insert_delete.sv
// array_list_insert_delete: ordered list of signed words in a row of cells.
// One command per cycle; the result strobe done_o rises in the cycle after accept.
// Throughput: one command each cycle, busy is never raised; every cell shifts in parallel.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the entry count and the result strobe; cell contents stay unknown
// until written and are never read before that.
module array_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [alc_pkg::CmdW-1:0]          cmd_i,
  input  logic [alc_pkg::PosW-1:0]          pos_i,
  input  logic signed [alc_pkg::DataW-1:0]  value_i,
  output logic                              done_o,
  output logic signed [alc_pkg::DataW-1:0]  data_o,
  output logic [alc_pkg::StatusW-1:0]       status_o,
  output logic [alc_pkg::CountW-1:0]        count_o,
  output logic                              empty_res_o,
  output logic                              full_res_o
);

  // count needs to hold CAPACITY itself
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // compare width covers both the count and any position
  localparam int unsigned CmpW = (CntW > alc_pkg::PosW) ? CntW : alc_pkg::PosW;
  // only positions 0..15 are addressable, so the read mux spans at most 16 cells
  localparam int unsigned NRd  = (CAPACITY < 16) ? CAPACITY : 16;
  localparam int unsigned RdW  = $clog2(NRd);

  logic [CntW-1:0]                  count_q, count_d;
  logic                             done_q;
  logic [alc_pkg::DataW-1:0]        data_q, data_d;
  alc_pkg::status_e                 status_q, status_d;

  logic                             accept;
  logic [CmpW-1:0]                  pos_x, cnt_x;
  logic                             is_full;
  logic                             ins_ok, del_ok, rd_ok;

  logic [alc_pkg::DataW-1:0]        cell_word [CAPACITY];
  logic [alc_pkg::DataW-1:0]        rd_word   [NRd];
  logic [alc_pkg::DataW-1:0]        rd_data;
  alc_pkg::cell_ctl_t               cell_ctl  [CAPACITY];

  // one command finishes per cycle, nothing to hold off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_x   = CmpW'(pos_i);
  assign cnt_x   = CmpW'(count_q);
  assign is_full = (count_q == CntW'(CAPACITY));

  // command decode and status
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    rd_ok    = 1'b0;
    status_d = alc_pkg::ST_OK;
    case (alc_pkg::cmd_e'(cmd_i))
      alc_pkg::CMD_READ: begin
        if (pos_x < cnt_x) rd_ok = 1'b1;
        else               status_d = alc_pkg::ST_RANGE;
      end
      alc_pkg::CMD_INSERT: begin
        // full check wins over the position check
        if (is_full)             status_d = alc_pkg::ST_FULL;
        else if (pos_x > cnt_x)  status_d = alc_pkg::ST_RANGE;
        else                     ins_ok = 1'b1;
      end
      alc_pkg::CMD_DELETE: begin
        if (pos_x < cnt_x) del_ok = 1'b1;
        else               status_d = alc_pkg::ST_RANGE;
      end
      default: begin
        // unused code: no-op, status ok
      end
    endcase
  end

  // read port over the addressable cells
  for (genvar r = 0; r < NRd; r++) begin : g_rd
    assign rd_word[r] = cell_word[r];
  end
  assign rd_data = rd_word[RdW'(pos_i)];

  always_comb begin
    data_d  = '0;
    count_d = count_q;
    if (accept) begin
      if (rd_ok || del_ok) data_d = rd_data;
      if (ins_ok)          count_d = count_q + CntW'(1);
      else if (del_ok)     count_d = count_q - CntW'(1);
    end
  end

  // cell row: each cell picks its source from its index against pos
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [alc_pkg::DataW-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    always_comb begin
      cell_ctl[i]            = '0;
      cell_ctl[i].load_val   = accept && ins_ok && (CmpW'(i) == pos_x);
      cell_ctl[i].take_left  = accept && ins_ok && (CmpW'(i) >  pos_x);
      cell_ctl[i].take_right = accept && del_ok && (CmpW'(i) >= pos_x);
    end

    alc_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  assign done_o      = done_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign count_o     = alc_pkg::CountW'(count_q);
  assign empty_res_o = (count_q == '0);
  assign full_res_o  = is_full;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("no result after accepted word");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_ok) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the list");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_d != alc_pkg::ST_OK)) |=> $stable(count_q))
    else $error("failed command changed the count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q == alc_pkg::ST_FULL)) |-> full_res_o)
    else $error("full status on a list that is not full");

endmodule
